// ===== sv/cbt_pkg.sv =====
package cbt_pkg;

  // Field widths of the result word
  localparam int REC_OUT_W   = 24;
  localparam int FIELD_OUT_W = 16;

  // Default counter widths
  localparam int FIELD_COUNT_BITS_DEF  = 16;
  localparam int RECORD_COUNT_BITS_DEF = 24;

  // Result queue
  localparam int QUEUE_DEPTH = 8;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int LVL_W       = $clog2(QUEUE_DEPTH + 1);

  // Delimiter after reset: comma
  localparam logic [7:0] DELIM_RESET = 8'd44;

  // Special characters
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // Input opcodes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  // Result kinds
  localparam logic [2:0] KIND_BYTE       = 3'd0;
  localparam logic [2:0] KIND_FIELD_END  = 3'd1;
  localparam logic [2:0] KIND_RECORD_END = 3'd2;
  localparam logic [2:0] KIND_ERROR      = 3'd3;
  localparam logic [2:0] KIND_DONE       = 3'd4;

  // Error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_OPEN_QUOT = 2'd1;
  localparam logic [1:0] ERR_NO_HEADER = 2'd2;
  localparam logic [1:0] ERR_COUNT     = 2'd3;

  typedef struct packed {
    logic       opcode;
    logic [7:0] text_byte;
  } in_word_t;

  typedef struct packed {
    logic [2:0]             result_kind;
    logic [7:0]             content_byte;
    logic [1:0]             err_code;
    logic [REC_OUT_W-1:0]   record_number;
    logic [FIELD_OUT_W-1:0] fields_in_record;
    logic                   run_last;
  } out_word_t;

  // Up to two result words pushed into the queue in one cycle
  typedef struct packed {
    logic [1:0] n;
    out_word_t  w0;
    out_word_t  w1;
  } res_push_t;

endpackage

// ===== sv/cbt_scan.sv =====
module cbt_scan import cbt_pkg::*; #(
  parameter int FIELD_COUNT_BITS  = FIELD_COUNT_BITS_DEF,
  parameter int RECORD_COUNT_BITS = RECORD_COUNT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  in_word_t         item,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_wdata,
  input  logic [LVL_W-1:0] level,
  output res_push_t        push
);

  typedef enum logic [1:0] {ST_START, ST_UNQ, ST_QUOTED, ST_QQ} scan_t;

  localparam int SUM_W = LVL_W + 1;

  logic                         stg_valid;
  in_word_t                     stg;
  logic [7:0]                   delim;
  scan_t                        st, st_next;
  logic                         crp, crp_next;
  logic [FIELD_COUNT_BITS-1:0]  rfc, rfc_next;
  logic [FIELD_COUNT_BITS-1:0]  hfc, hfc_next;
  logic [RECORD_COUNT_BITS-1:0] rc, rc_next;
  logic                         el, el_next;

  function automatic out_word_t mk_word(input logic [2:0] kind, input logic [7:0] cb,
                                        input logic [1:0] ec,
                                        input logic [REC_OUT_W-1:0] rec,
                                        input logic [FIELD_OUT_W-1:0] fld);
    out_word_t w;
    w.result_kind      = kind;
    w.content_byte     = cb;
    w.err_code         = ec;
    w.record_number    = rec;
    w.fields_in_record = fld;
    w.run_last         = 1'b0;
    return w;
  endfunction

  // Room for two words from the stage and two from a new word
  assign item_ready = (SUM_W'(level) + (stg_valid ? SUM_W'(2) : SUM_W'(0)))
                      <= SUM_W'(QUEUE_DEPTH - 2);

  // Record end shared by line breaks and flush
  logic [FIELD_COUNT_BITS-1:0]  re_cnt;
  logic [RECORD_COUNT_BITS-1:0] rc_inc;
  logic                         re_hdr, re_bad;
  out_word_t                    re_word;

  always_comb begin
    re_cnt  = (rfc == '1) ? rfc : rfc + 1'b1;
    rc_inc  = (rc == '1) ? rc : rc + 1'b1;
    re_hdr  = (rc == '0);
    re_bad  = !re_hdr && (re_cnt != hfc);
    re_word = mk_word(re_bad ? KIND_ERROR : KIND_RECORD_END, 8'd0,
                      re_bad ? ERR_COUNT : ERR_NONE,
                      REC_OUT_W'(rc), FIELD_OUT_W'(re_cnt));
  end

  // Scanner decision
  logic [7:0] c;
  logic       brk, do_byte, do_fe, do_re;

  always_comb begin
    c        = stg.text_byte;
    brk      = (c == CH_CR) || (c == CH_LF);
    do_byte  = 1'b0;
    do_fe    = 1'b0;
    do_re    = 1'b0;
    st_next  = st;
    crp_next = crp;
    rfc_next = rfc;
    hfc_next = hfc;
    rc_next  = rc;
    el_next  = el;
    push     = '0;

    if (stg_valid && stg.opcode == OP_BYTE && !el) begin
      crp_next = 1'b0;
      if (!(crp && c == CH_LF)) begin
        case (st)
          ST_START: begin
            if (c == CH_QUOTE) st_next = ST_QUOTED;
            else if (c == delim) do_fe = 1'b1;
            else if (brk) do_re = 1'b1;
            else begin
              st_next = ST_UNQ;
              do_byte = 1'b1;
            end
          end
          ST_UNQ: begin
            if (c == delim) do_fe = 1'b1;
            else if (brk) do_re = 1'b1;
            else do_byte = 1'b1;
          end
          ST_QUOTED: begin
            if (c == CH_QUOTE) st_next = ST_QQ;
            else do_byte = 1'b1;
          end
          ST_QQ: begin
            if (c == CH_QUOTE) begin
              // doubled quote: literal quote, back inside quotes
              st_next = ST_QUOTED;
              do_byte = 1'b1;
            end else if (c == delim) do_fe = 1'b1;
            else if (brk) do_re = 1'b1;
            else begin
              st_next = ST_UNQ;
              do_byte = 1'b1;
            end
          end
          default: st_next = ST_START;
        endcase
      end

      if (do_byte) begin
        push.n  = 2'd1;
        push.w0 = mk_word(KIND_BYTE, c, ERR_NONE, REC_OUT_W'(rc), '0);
      end else if (do_fe) begin
        rfc_next = re_cnt;
        st_next  = ST_START;
        push.n   = 2'd1;
        push.w0  = mk_word(KIND_FIELD_END, 8'd0, ERR_NONE, REC_OUT_W'(rc), '0);
      end else if (do_re) begin
        crp_next = (c == CH_CR);
        rfc_next = '0;
        st_next  = ST_START;
        if (re_hdr) hfc_next = re_cnt;
        if (re_bad) el_next = 1'b1;
        else rc_next = rc_inc;
        push.n  = 2'd1;
        push.w0 = re_word;
      end
      push.w0.run_last = 1'b1;
    end else if (stg_valid && stg.opcode == OP_END) begin
      // End of input: flush, report, done, then re-arm
      if (el) begin
        push.n  = 2'd1;
        push.w0 = mk_word(KIND_DONE, 8'd0, ERR_NONE, REC_OUT_W'(rc), '0);
      end else if (st == ST_QUOTED) begin
        push.n  = 2'd2;
        push.w0 = mk_word(KIND_ERROR, 8'd0, ERR_OPEN_QUOT, REC_OUT_W'(rc), '0);
        push.w1 = mk_word(KIND_DONE, 8'd0, ERR_NONE, REC_OUT_W'(rc), '0);
      end else if (st != ST_START || rfc != '0) begin
        push.n  = 2'd2;
        push.w0 = re_word;
        push.w1 = mk_word(KIND_DONE, 8'd0, ERR_NONE,
                          REC_OUT_W'(re_bad ? rc : rc_inc), '0);
      end else if (re_hdr) begin
        push.n  = 2'd2;
        push.w0 = mk_word(KIND_ERROR, 8'd0, ERR_NO_HEADER, '0, '0);
        push.w1 = mk_word(KIND_DONE, 8'd0, ERR_NONE, '0, '0);
      end else begin
        push.n  = 2'd1;
        push.w0 = mk_word(KIND_DONE, 8'd0, ERR_NONE, REC_OUT_W'(rc), '0);
      end
      if (push.n == 2'd2) push.w1.run_last = 1'b1;
      else push.w0.run_last = 1'b1;
      st_next  = ST_START;
      crp_next = 1'b0;
      rfc_next = '0;
      hfc_next = '0;
      rc_next  = '0;
      el_next  = 1'b0;
    end
  end

  // Input stage, scanner state and delimiter register
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
      delim     <= DELIM_RESET;
      st        <= ST_START;
      crp       <= 1'b0;
      rfc       <= '0;
      hfc       <= '0;
      rc        <= '0;
      el        <= 1'b0;
    end else begin
      stg_valid <= item_valid && item_ready;
      if (cfg_we) delim <= cfg_wdata;
      st  <= st_next;
      crp <= crp_next;
      rfc <= rfc_next;
      hfc <= hfc_next;
      rc  <= rc_next;
      el  <= el_next;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) stg <= item;
  end

  // Two words in one cycle only at end of input
  a_pair_only_at_end: assert property (@(posedge clk) disable iff (rst)
    push.n == 2'd2 |-> (stg_valid && stg.opcode == OP_END))
    else $error("two result words from a text byte");

  // The last pushed word carries run_last, and only that one
  a_run_last: assert property (@(posedge clk) disable iff (rst)
    push.n != 2'd0 |-> ((push.n == 2'd1) ? push.w0.run_last
                                          : (push.w1.run_last && !push.w0.run_last)))
    else $error("run_last misplaced");

  // End of input re-arms the scanner
  a_rearm: assert property (@(posedge clk) disable iff (rst)
    (stg_valid && stg.opcode == OP_END) |=>
      (st == ST_START && !crp && rfc == '0 && hfc == '0 && rc == '0 && !el))
    else $error("scanner not re-armed after end of input");

endmodule

// ===== sv/cbt_fifo.sv =====
module cbt_fifo import cbt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  res_push_t        push,
  input  logic             pop,
  output out_word_t        head,
  output logic [LVL_W-1:0] level
);

  out_word_t        mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wp, rp;
  logic [PTR_W-1:0] wp1;

  assign wp1  = wp + PTR_W'(1);
  assign head = mem[rp];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      level <= '0;
    end else begin
      wp    <= wp + PTR_W'(push.n);
      if (pop) rp <= rp + PTR_W'(1);
      level <= level + LVL_W'(push.n) - LVL_W'(pop);
    end
  end

  // Storage, up to two words written per cycle
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem[wp] <= push.w0;
    if (push.n == 2'd2) mem[wp1] <= push.w1;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (LVL_W + 2)'(level) + (LVL_W + 2)'(push.n) <= (LVL_W + 2)'(QUEUE_DEPTH))
    else $error("result queue overflow");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && push.n == 2'd0) |=> level == $past(level) - LVL_W'(1))
    else $error("result queue level not decremented on pop");

endmodule

// ===== sv/csv_byte_tokenizer.sv =====
// CSV tokenizer, one text byte per cycle while item_ready is high.
// Input channel item_valid/item_ready carries an in_word_t: opcode selects
// a text byte or end of input. Output channel result_valid/result_ready
// carries out_word_t words: field bytes, field ends, record ends, errors
// and done, with run_last set on the last word caused by each input word.
// A text byte gives zero or one result word; end of input gives one or two.
// A word taken is registered in the input stage, scanned from that
// register and written to an eight-entry result queue, from which its
// results are offered. Throughput is one input word per cycle while
// item_ready is high; the queue keeps accepting while results wait,
// and item_ready drops once the queue has no room for two more
// words beyond those still owed by the word in the input register.
// cfg_we/cfg_wdata load the delimiter; write only while idle.
// Reset (rst, synchronous) empties the queue, sets the delimiter to comma
// and clears the scanner. A stalled receiver fills the queue, and then
// item_ready stays low until words are taken again.
module csv_byte_tokenizer import cbt_pkg::*; #(
  parameter int FIELD_COUNT_BITS  = FIELD_COUNT_BITS_DEF,
  parameter int RECORD_COUNT_BITS = RECORD_COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  in_word_t   item,
  output logic       result_valid,
  input  logic       result_ready,
  output out_word_t  result,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  res_push_t        push;
  logic [LVL_W-1:0] level;

  cbt_scan #(
    .FIELD_COUNT_BITS  (FIELD_COUNT_BITS),
    .RECORD_COUNT_BITS (RECORD_COUNT_BITS)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .level      (level),
    .push       (push)
  );

  cbt_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (result_valid && result_ready),
    .head  (result),
    .level (level)
  );

  assign result_valid = (level != '0);

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import cbt_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES = 8;
  localparam int WORDS_PER_PHASE = 50;
  localparam int SETTLE_CYCLES = 6;

  // Scanner states of the tokenizer
  localparam logic [1:0] S_START  = 2'd0;
  localparam logic [1:0] S_UNQ    = 2'd1;
  localparam logic [1:0] S_QUOTED = 2'd2;
  localparam logic [1:0] S_QQ     = 2'd3;

  typedef struct {
    in_word_t  w;
    int        n_typed;
    out_word_t t0;
    out_word_t t1;
  } stim_row_t;

  logic      clk;
  logic      rst;
  logic      item_valid;
  logic      item_ready;
  in_word_t  item;
  logic      result_valid;
  logic      result_ready;
  out_word_t result;
  logic      cfg_we;
  logic [7:0] cfg_wdata;

  csv_byte_tokenizer dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  // Tokenizer state as tracked by the testbench
  logic [7:0]                       delim;
  logic [1:0]                       scan_st;
  logic                             cr_wait;
  logic [FIELD_COUNT_BITS_DEF-1:0]  rec_fields;
  logic [FIELD_COUNT_BITS_DEF-1:0]  hdr_fields;
  logic [RECORD_COUNT_BITS_DEF-1:0] rec_count;
  logic                             err_latched;

  out_word_t step_words[$];
  out_word_t expected_words[$];
  stim_row_t directed[$];

  int mismatch_count;
  int words_sent;
  int quiet_cycles;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_request;
  int hold_left;

  logic [7:0] phase_delim [PHASES] = '{8'd44, 8'h00, 8'hFF, CH_QUOTE, CH_CR, CH_LF,
                                       8'h3B, 8'h09};
  int phase_send_pct [4] = '{0, 61, 0, 10};
  int phase_recv_pct [4] = '{0, 0, 61, 10};

  function automatic out_word_t out_word(logic [2:0] k, logic [7:0] b, logic [1:0] e,
                                         int r, int f, bit l);
    out_word_t o;
    o.result_kind      = k;
    o.content_byte     = b;
    o.err_code         = e;
    o.record_number    = REC_OUT_W'(r);
    o.fields_in_record = FIELD_OUT_W'(f);
    o.run_last         = l;
    return o;
  endfunction

  function automatic in_word_t byte_word(logic [7:0] b);
    in_word_t w;
    w.opcode    = OP_BYTE;
    w.text_byte = b;
    return w;
  endfunction

  function automatic in_word_t end_word(logic [7:0] b);
    in_word_t w;
    w.opcode    = OP_END;
    w.text_byte = b;
    return w;
  endfunction

  function automatic bit roll(int pct);
    return $urandom_range(99) < pct;
  endfunction

  // ---------------- tokenizer prediction ----------------

  task automatic add_word(logic [2:0] k, logic [7:0] b, logic [1:0] e,
                          logic [RECORD_COUNT_BITS_DEF-1:0] r,
                          logic [FIELD_COUNT_BITS_DEF-1:0] f);
    step_words = {step_words, out_word(k, b, e, int'(r), int'(f), 1'b0)};
  endtask

  task automatic close_field();
    if (rec_fields != '1) rec_fields = rec_fields + 1'b1;
    scan_st = S_START;
    add_word(KIND_FIELD_END, 8'h00, ERR_NONE, rec_count, '0);
  endtask

  // Record end also closes the last field; count mismatch turns it into an error
  task automatic close_record();
    logic [FIELD_COUNT_BITS_DEF-1:0] n;
    n = (rec_fields == '1) ? rec_fields : rec_fields + 1'b1;
    rec_fields = '0;
    scan_st = S_START;
    if (rec_count != 0 && n != hdr_fields) begin
      err_latched = 1'b1;
      add_word(KIND_ERROR, 8'h00, ERR_COUNT, rec_count, n);
    end else begin
      if (rec_count == 0) hdr_fields = n;
      add_word(KIND_RECORD_END, 8'h00, ERR_NONE, rec_count, n);
      if (rec_count != '1) rec_count = rec_count + 1'b1;
    end
  endtask

  task automatic line_break(logic [7:0] c);
    if (c == CH_CR) cr_wait = 1'b1;
    close_record();
  endtask

  task automatic clear_scanner();
    scan_st     = S_START;
    cr_wait     = 1'b0;
    rec_fields  = '0;
    hdr_fields  = '0;
    rec_count   = '0;
    err_latched = 1'b0;
  endtask

  task automatic tokenize_word(in_word_t w);
    logic [7:0] c;
    bit swallow;
    bit brk;
    c = w.text_byte;
    swallow = 1'b0;
    step_words = {};
    if (w.opcode == OP_END) begin
      if (!err_latched) begin
        if (scan_st == S_QUOTED) begin
          add_word(KIND_ERROR, 8'h00, ERR_OPEN_QUOT, rec_count, '0);
        end else begin
          if (scan_st != S_START || rec_fields != 0) close_record();
          if (!err_latched && rec_count == 0)
            add_word(KIND_ERROR, 8'h00, ERR_NO_HEADER, '0, '0);
        end
      end
      add_word(KIND_DONE, 8'h00, ERR_NONE, rec_count, '0);
      clear_scanner();
    end else if (!err_latched) begin
      // LF right after a record-ending CR is swallowed
      if (cr_wait) begin
        cr_wait = 1'b0;
        if (c == CH_LF) swallow = 1'b1;
      end
      brk = (c == CH_CR || c == CH_LF);
      if (!swallow) begin
        case (scan_st)
          S_START: begin
            if (c == CH_QUOTE) scan_st = S_QUOTED;
            else if (c == delim) close_field();
            else if (brk) line_break(c);
            else begin
              scan_st = S_UNQ;
              add_word(KIND_BYTE, c, ERR_NONE, rec_count, '0);
            end
          end
          S_UNQ: begin
            if (c == delim) close_field();
            else if (brk) line_break(c);
            else add_word(KIND_BYTE, c, ERR_NONE, rec_count, '0);
          end
          S_QUOTED: begin
            if (c == CH_QUOTE) scan_st = S_QQ;
            else add_word(KIND_BYTE, c, ERR_NONE, rec_count, '0);
          end
          default: begin
            // closing quote seen: doubled quote, separator, break or trailing text
            if (c == CH_QUOTE) begin
              scan_st = S_QUOTED;
              add_word(KIND_BYTE, CH_QUOTE, ERR_NONE, rec_count, '0);
            end else if (c == delim) close_field();
            else if (brk) line_break(c);
            else begin
              scan_st = S_UNQ;
              add_word(KIND_BYTE, c, ERR_NONE, rec_count, '0);
            end
          end
        endcase
      end
    end
    if (step_words.size() > 0) step_words[step_words.size()-1].run_last = 1'b1;
  endtask

  // ---------------- clock, reset, watchdog ----------------

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((item_valid && item_ready) || (result_valid && result_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: watchdog expired, %0d words still expected", $time,
               expected_words.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------- result side ----------------

  initial begin
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        result_ready <= 1'b0;
      end else begin
        result_ready <= !roll(recv_idle_pct);
      end
    end
  end

  task automatic mismatch(string name, logic [31:0] e, logic [31:0] a);
    mismatch_count = mismatch_count + 1;
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, a);
  endtask

  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst && result_valid && result_ready) begin
      if (expected_words.size() == 0) begin
        mismatch_count = mismatch_count + 1;
        $display("%0t: unexpected word, kind %0h byte %0h", $time,
                 result.result_kind, result.content_byte);
      end else begin
        exp_w = expected_words.pop_front();
        if (result.result_kind !== exp_w.result_kind)
          mismatch("result_kind", 32'(exp_w.result_kind), 32'(result.result_kind));
        if (result.content_byte !== exp_w.content_byte)
          mismatch("content_byte", 32'(exp_w.content_byte), 32'(result.content_byte));
        if (result.err_code !== exp_w.err_code)
          mismatch("err_code", 32'(exp_w.err_code), 32'(result.err_code));
        if (result.record_number !== exp_w.record_number)
          mismatch("record_number", 32'(exp_w.record_number),
                   32'(result.record_number));
        if (result.fields_in_record !== exp_w.fields_in_record)
          mismatch("fields_in_record", 32'(exp_w.fields_in_record),
                   32'(result.fields_in_record));
        if (result.run_last !== exp_w.run_last)
          mismatch("run_last", 32'(exp_w.run_last), 32'(result.run_last));
      end
    end
  end

  // ---------------- input side ----------------

  // Typed expectations, where given, replace the predicted ones
  task automatic send_word(in_word_t w, int n_typed = -1, out_word_t t0 = '0,
                           out_word_t t1 = '0);
    @(negedge clk);
    while (roll(send_idle_pct)) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= w;
    do @(posedge clk); while (!item_ready);
    words_sent = words_sent + 1;
    tokenize_word(w);
    if (n_typed >= 0) begin
      step_words = {};
      if (n_typed > 0) step_words = {step_words, t0};
      if (n_typed > 1) step_words = {step_words, t1};
    end
    expected_words = {expected_words, step_words};
  endtask

  // Stop sending and wait for every expected word, plus the pipeline depth
  task automatic drain();
    @(negedge clk);
    item_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_delimiter(logic [7:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    delim = v;
  endtask

  task automatic add_row(in_word_t w, int n = -1, out_word_t t0 = '0, out_word_t t1 = '0);
    stim_row_t r;
    r.w = w;
    r.n_typed = n;
    r.t0 = t0;
    r.t1 = t1;
    directed = {directed, r};
  endtask

  function automatic logic [7:0] any_text();
    if ($urandom_range(1)) return 8'(8'h61 + $urandom_range(25));
    return 8'($urandom_range(255));
  endfunction

  task automatic send_field();
    int len;
    logic [7:0] b;
    len = $urandom_range(3);
    if ($urandom_range(2) == 0) begin
      // quoted field, inner quotes doubled
      send_word(byte_word(CH_QUOTE));
      repeat (len) begin
        b = any_text();
        send_word(byte_word(b));
        if (b == CH_QUOTE) send_word(byte_word(CH_QUOTE));
      end
      send_word(byte_word(CH_QUOTE));
      if ($urandom_range(7) == 0) send_word(byte_word(8'(8'h61 + $urandom_range(25))));
    end else begin
      for (int i = 0; i < len; i++) begin
        do b = any_text();
        while (b == delim || b == CH_CR || b == CH_LF || (i == 0 && b == CH_QUOTE));
        send_word(byte_word(b));
      end
    end
  endtask

  // One CSV text: header plus records, mostly well formed, then end of input
  task automatic send_document();
    int nf;
    int nrec;
    int cnt;
    nf = $urandom_range(1, 4);
    nrec = $urandom_range(1, 4);
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 8)) send_word(in_word_t'(9'($urandom_range(511))));
    end else begin
      for (int r = 0; r < nrec; r++) begin
        cnt = nf;
        if (r > 0 && $urandom_range(9) == 0) cnt = $urandom_range(1, 5);
        for (int f = 0; f < cnt; f++) begin
          if (f > 0) send_word(byte_word(delim));
          send_field();
        end
        if (!(r == nrec - 1 && $urandom_range(3) == 0)) begin
          case ($urandom_range(2))
            0: send_word(byte_word(CH_CR));
            1: send_word(byte_word(CH_LF));
            default: begin
              send_word(byte_word(CH_CR));
              send_word(byte_word(CH_LF));
            end
          endcase
        end
      end
      if ($urandom_range(7) == 0) begin
        send_word(byte_word(CH_QUOTE));
        send_word(byte_word(any_text()));
      end
    end
    send_word(end_word(8'($urandom_range(255))));
  endtask

  // ---------------- main sequence ----------------

  initial begin
    int phase_start;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    result_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 8'h00;
    mismatch_count = 0;
    words_sent = 0;
    quiet_cycles = 0;
    hold_request = 0;
    send_idle_pct = 10;
    recv_idle_pct = 10;
    delim = DELIM_RESET;
    clear_scanner();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed text with the default comma delimiter
    add_row(end_word(8'hFF), 2, out_word(KIND_ERROR, 8'h00, ERR_NO_HEADER, 0, 0, 1'b0),
            out_word(KIND_DONE, 8'h00, ERR_NONE, 0, 0, 1'b1));
    add_row(byte_word(8'h61), 1, out_word(KIND_BYTE, 8'h61, ERR_NONE, 0, 0, 1'b1));
    add_row(byte_word(8'h2C), 1, out_word(KIND_FIELD_END, 8'h00, ERR_NONE, 0, 0, 1'b1));
    add_row(byte_word(CH_QUOTE));
    add_row(byte_word(CH_QUOTE));
    add_row(byte_word(CH_QUOTE));
    add_row(byte_word(CH_CR));
    add_row(byte_word(8'hFF), 1, out_word(KIND_BYTE, 8'hFF, ERR_NONE, 0, 0, 1'b1));
    add_row(byte_word(CH_QUOTE));
    add_row(byte_word(8'h78));
    add_row(byte_word(CH_CR));
    add_row(byte_word(CH_LF));
    add_row(byte_word(8'h00), 1, out_word(KIND_BYTE, 8'h00, ERR_NONE, 1, 0, 1'b1));
    add_row(byte_word(8'h2C));
    add_row(byte_word(CH_LF));
    add_row(byte_word(CH_LF), 1, out_word(KIND_ERROR, 8'h00, ERR_COUNT, 2, 1, 1'b1));
    add_row(byte_word(8'h7A));
    add_row(end_word(8'h00), 1, out_word(KIND_DONE, 8'h00, ERR_NONE, 2, 0, 1'b1));
    add_row(byte_word(CH_QUOTE));
    add_row(byte_word(8'h80));
    add_row(end_word(8'h55), 2, out_word(KIND_ERROR, 8'h00, ERR_OPEN_QUOT, 0, 0, 1'b0),
            out_word(KIND_DONE, 8'h00, ERR_NONE, 0, 0, 1'b1));
    add_row(byte_word(8'h61));
    add_row(end_word(8'hAA));
    foreach (directed[i])
      send_word(directed[i].w, directed[i].n_typed, directed[i].t0, directed[i].t1);
    drain();

    // Random documents under several delimiters and idling patterns
    for (int p = 0; p < PHASES; p++) begin
      set_delimiter(phase_delim[p]);
      send_idle_pct = phase_send_pct[p % 4];
      recv_idle_pct = phase_recv_pct[p % 4];
      if (p == 0) hold_request = HOLD_CYCLES;
      phase_start = words_sent;
      while (words_sent - phase_start < WORDS_PER_PHASE) send_document();
      drain();
    end

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
